[rtl/sfc_pkg.sv]
package sfc_pkg;

	localparam int unsigned COORD_W       = 16;
	localparam int unsigned NORM_W        = 16;
	localparam int unsigned PROD_W        = 2 * COORD_W;
	localparam int unsigned OFS_SUM_W     = COORD_W + 1;
	localparam int unsigned OFS_ALIGN_SH  = 14;
	localparam int unsigned SUM_W         = 36;
	localparam int unsigned PLANE_W       = 64;
	localparam int unsigned NUM_PLANE_REGS = 6;
	localparam int unsigned PLANE_COUNT_DEF = 6;
	localparam int unsigned PADDR_W       = 6;
	localparam int unsigned PDATA_W       = 64;
	localparam int unsigned REG_IDX_W     = 3;

	// register indexes (byte address / 8)
	localparam logic [REG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_FAR    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd5;

	typedef logic [NUM_PLANE_REGS-1:0][PLANE_W-1:0] plane_set_t;

	// object as it travels down the chain of plane cells
	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic signed [COORD_W-1:0] radius;
		logic                      vis;
	} obj_item_t;

endpackage

[rtl/sfc_if.sv]
interface sfc_obj_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] center_x;
	logic signed [15:0] center_y;
	logic signed [15:0] center_z;
	logic signed [15:0] scale_x;
	logic signed [15:0] scale_y;
	logic signed [15:0] scale_z;
	logic               has_bounds;

	modport source (output valid, center_x, center_y, center_z, scale_x, scale_y, scale_z,
		has_bounds, input ready);
	modport sink (input valid, center_x, center_y, center_z, scale_x, scale_y, scale_z,
		has_bounds, output ready);
endinterface

interface sfc_vis_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

[rtl/sphere_frustum_cull.sv]
// Channel  Dir  Modport          Payload
// obj      in   sfc_obj_if.sink  center_x/y/z, scale_x/y/z (Q12.4), has_bounds
// res      out  sfc_vis_if.source visible
// cfg      in   APB              six 64-bit plane registers at byte address 8*i
//
// Throughput is one object per cycle while res.ready does not stall; each object
// passes the input stage and then the two registers inside each plane cell.
// Each stage holds its own request and takes a new one as soon as it is empty
// or its neighbor takes its contents, so bubbles collapse under a stall.
// Reset (arst_n low) empties the pipeline and clears all plane registers.
module sphere_frustum_cull #(
	parameter int unsigned PLANE_COUNT = sfc_pkg::PLANE_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sfc_obj_if.sink                      obj,
	sfc_vis_if.source                    res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfc_pkg::PADDR_W-1:0]  paddr,
	input  logic [sfc_pkg::PDATA_W-1:0]  pwdata,
	output logic [sfc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	sfc_pkg::plane_set_t                planes;

	// input stage: radius is the signed max of the three scales
	logic                               valid_s0;
	logic                               ready_s0;
	sfc_pkg::obj_item_t                 item_s0;
	logic signed [sfc_pkg::COORD_W-1:0] r_xy, radius;

	// chain links: link k feeds cell k, link PLANE_COUNT is the result
	logic               [PLANE_COUNT:0] link_valid;
	logic               [PLANE_COUNT:0] link_ready;
	sfc_pkg::obj_item_t [PLANE_COUNT:0] link_item;

	sfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.planes  (planes)
	);

	assign r_xy   = (obj.scale_x > obj.scale_y) ? obj.scale_x : obj.scale_y;
	assign radius = (obj.scale_z > r_xy) ? obj.scale_z : r_xy;

	assign ready_s0  = !valid_s0 || link_ready[0];
	assign obj.ready = ready_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (ready_s0) begin
			valid_s0 <= obj.valid;
		end
	end

	// no bounding box: start the object as not visible, the cells only clear it
	always_ff @(posedge clk) begin
		if (ready_s0) begin
			item_s0.center_x <= obj.center_x;
			item_s0.center_y <= obj.center_y;
			item_s0.center_z <= obj.center_z;
			item_s0.radius   <= radius;
			item_s0.vis      <= obj.has_bounds;
		end
	end

	assign link_valid[0] = valid_s0;
	assign link_item[0]  = item_s0;

	// one cell per plane, in register order
	for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
		sfc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.plane     (planes[k]),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_item   (link_item[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_item  (link_item[k+1])
		);
	end

	assign res.valid               = link_valid[PLANE_COUNT];
	assign res.visible             = link_item[PLANE_COUNT].vis;
	assign link_ready[PLANE_COUNT] = res.ready;

`ifndef NO_ASSERTIONS
	a_take_in: assert property (@(posedge clk) disable iff (!arst_n)
		obj.valid && obj.ready |=> valid_s0 && (item_s0.vis == $past(obj.has_bounds)))
		else $error("accepted object not held in input stage");
`endif

endmodule

[rtl/sfc_cfg.sv]
module sfc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfc_pkg::PADDR_W-1:0]   paddr,
	input  logic [sfc_pkg::PDATA_W-1:0]   pwdata,
	output logic [sfc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output sfc_pkg::plane_set_t           planes
);

	sfc_pkg::plane_set_t                 planes_q;
	logic [sfc_pkg::REG_IDX_W-1:0]       reg_idx;
	logic                                wr_en;

	assign reg_idx = paddr[sfc_pkg::PADDR_W-1:3];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign planes  = planes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				sfc_pkg::REG_PLANE_RIGHT:  planes_q[0] <= pwdata;
				sfc_pkg::REG_PLANE_LEFT:   planes_q[1] <= pwdata;
				sfc_pkg::REG_PLANE_BOTTOM: planes_q[2] <= pwdata;
				sfc_pkg::REG_PLANE_TOP:    planes_q[3] <= pwdata;
				sfc_pkg::REG_PLANE_FAR:    planes_q[4] <= pwdata;
				sfc_pkg::REG_PLANE_NEAR:   planes_q[5] <= pwdata;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sfc_pkg::REG_PLANE_RIGHT:  prdata = planes_q[0];
			sfc_pkg::REG_PLANE_LEFT:   prdata = planes_q[1];
			sfc_pkg::REG_PLANE_BOTTOM: prdata = planes_q[2];
			sfc_pkg::REG_PLANE_TOP:    prdata = planes_q[3];
			sfc_pkg::REG_PLANE_FAR:    prdata = planes_q[4];
			sfc_pkg::REG_PLANE_NEAR:   prdata = planes_q[5];
			default:                   prdata = '0;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_near_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (reg_idx == sfc_pkg::REG_PLANE_NEAR) |=> planes_q[5] == $past(pwdata))
		else $error("near plane register missed its write");
`endif

endmodule

[rtl/sfc_cell.sv]
module sfc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sfc_pkg::PLANE_W-1:0]  plane,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  sfc_pkg::obj_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output sfc_pkg::obj_item_t           out_item
);

	logic signed [sfc_pkg::NORM_W-1:0]    nx, ny, nz;
	logic signed [sfc_pkg::COORD_W-1:0]   ofs;

	logic                                 valid_s1, valid_s2;
	logic                                 ready_s1, ready_s2;
	sfc_pkg::obj_item_t                   item_s1, item_s2;
	sfc_pkg::obj_item_t                   item_nxt;
	logic signed [sfc_pkg::PROD_W-1:0]    px_s1, py_s1, pz_s1;
	logic signed [sfc_pkg::OFS_SUM_W-1:0] ofs_r_s1;
	logic signed [sfc_pkg::SUM_W-1:0]     ofs_wide;
	logic signed [sfc_pkg::SUM_W-1:0]     dist_sum;
	logic                                 outside;

	assign nx  = plane[15:0];
	assign ny  = plane[31:16];
	assign nz  = plane[47:32];
	assign ofs = plane[63:48];

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// dist - r < -2r  <=>  n.c + (d + r) * 2^14 < 0
	assign ofs_wide = {{(sfc_pkg::SUM_W - sfc_pkg::OFS_SUM_W - sfc_pkg::OFS_ALIGN_SH)
		{ofs_r_s1[sfc_pkg::OFS_SUM_W-1]}}, ofs_r_s1, {sfc_pkg::OFS_ALIGN_SH{1'b0}}};
	assign dist_sum = sfc_pkg::SUM_W'(px_s1) + sfc_pkg::SUM_W'(py_s1)
		+ sfc_pkg::SUM_W'(pz_s1) + ofs_wide;
	assign outside  = dist_sum[sfc_pkg::SUM_W-1];

	// drop visibility once this plane culls the object
	always_comb begin
		item_nxt     = item_s1;
		item_nxt.vis = item_s1.vis && !outside;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			item_s1  <= in_item;
			px_s1    <= nx * in_item.center_x;
			py_s1    <= ny * in_item.center_y;
			pz_s1    <= nz * in_item.center_z;
			ofs_r_s1 <= sfc_pkg::OFS_SUM_W'(ofs) + sfc_pkg::OFS_SUM_W'(in_item.radius);
		end
		if (ready_s2) begin
			item_s2 <= item_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

`ifndef NO_ASSERTIONS
	a_vis_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 && !item_s1.vis |=> !item_s2.vis)
		else $error("culled object became visible again");
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2)
		else $error("stalled result dropped from cell");
`endif

endmodule
